### rtl/tfr_pkg.sv
// ----------------------------------------------------------------------------
// tfr_pkg - shared types and constants of the text find and replace stream
// Sizes, the configuration register map, the control-to-output job record
// and the case folding helper.
// ----------------------------------------------------------------------------
`default_nettype none

package tfr_pkg;

  // sizes
  localparam int PATTERN_MAX = 16;
  localparam int REPLACE_MAX = 16;
  localparam int COUNT_BITS  = 32;
  localparam int CFG_BYTES   = 16;   // two 64-bit words of bytes
  localparam int LIST_MAX    = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;
  localparam int LEN_W       = $clog2(LIST_MAX + 1);
  localparam int POS_W       = (LIST_MAX > 1) ? $clog2(LIST_MAX) : 1;
  localparam int CFG_IDX_W   = 3;

  localparam logic [7:0] NEWLINE = 8'd10;

  typedef logic [7:0] byte_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LO  = 3'd0,
    CFG_PAT_HI  = 3'd1,
    CFG_PAT_LEN = 3'd2,
    CFG_REP_LO  = 3'd3,
    CFG_REP_HI  = 3'd4,
    CFG_REP_LEN = 3'd5,
    CFG_FIRST   = 3'd6
  } cfg_idx_t;

  // live configuration, lengths already clamped
  typedef struct packed {
    byte_t [CFG_BYTES-1:0] pattern;
    logic  [LEN_W-1:0]     pattern_len;
    byte_t [CFG_BYTES-1:0] replace;
    logic  [LEN_W-1:0]     replace_len;
    logic                  first_per_line;
  } cfg_t;

  // one input's worth of output beats
  typedef struct packed {
    logic                  rep;         // beats come from the replacement
    byte_t [LIST_MAX-1:0]  bytes;       // held bytes then the new byte
    logic  [LEN_W-1:0]     count;       // beats in this job, never zero
    logic  [COUNT_BITS-1:0] total;      // match total shown on every beat
    logic                  stream_end;  // final job of the stream
  } job_t;

  // ascii upper case to lower case
  function automatic byte_t fold_case(input byte_t c);
    byte_t r;
    r = c;
    if (c >= 8'd65 && c <= 8'd90) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/tfr_front.sv
// ----------------------------------------------------------------------------
// tfr_front - input side of the text find and replace stream
// Takes one text byte per beat, keeps the match window, compares against the
// pattern and hands a job describing the resulting beats to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tfr_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire tfr_pkg::cfg_t   cfg,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire tfr_pkg::byte_t  in_byte,
  input  wire logic            in_end,
  output logic                 job_valid,
  input  wire logic            job_ready,
  output tfr_pkg::job_t        job
);
  import tfr_pkg::*;

  byte_t                 window [PATTERN_MAX];
  byte_t                 window_next [PATTERN_MAX];
  logic [LEN_W-1:0]      held_count;
  logic [LEN_W-1:0]      held_count_next;
  logic                  line_matched;
  logic                  line_matched_next;
  logic [COUNT_BITS-1:0] match_counter;
  logic [COUNT_BITS-1:0] match_counter_next;
  logic [COUNT_BITS-1:0] total_after;

  logic                  accept;
  logic                  is_nl;
  logic                  active;
  logic                  flush;
  logic                  store;
  logic                  compare;
  logic                  hit;
  logic                  miss;
  logic [LEN_W-1:0]      held_inc;
  logic [POS_W-1:0]      last_idx;
  logic [LEN_W-1:0]      beats;

  assign in_ready = job_ready;
  assign accept   = in_valid && in_ready;

  // classify the incoming byte
  always_comb begin
    held_inc = held_count + LEN_W'(1);
    is_nl    = (in_byte == NEWLINE);
    active   = (cfg.pattern_len != '0) && !(cfg.first_per_line && line_matched)
               && (held_count < cfg.pattern_len);
    flush    = is_nl || !active;
    store    = !flush && (held_inc < cfg.pattern_len);
    compare  = !flush && !store;
    last_idx = POS_W'(cfg.pattern_len - LEN_W'(1));

    // new byte against the final pattern byte, held bytes against the rest
    hit = compare && (fold_case(in_byte) == fold_case(cfg.pattern[last_idx]));
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (LEN_W'(i) < held_count && fold_case(window[i]) != fold_case(cfg.pattern[i])) begin
        hit = 1'b0;
      end
    end
    miss = compare && !hit;
  end

  // match total after this byte, saturating
  always_comb begin
    total_after = match_counter;
    if (hit && match_counter != {COUNT_BITS{1'b1}}) begin
      total_after = match_counter + COUNT_BITS'(1);
    end
  end

  // job for the output side
  always_comb begin
    if (hit) begin
      beats = cfg.replace_len;
    end else if (flush) begin
      beats = held_inc;
    end else if (store) begin
      beats = in_end ? held_inc : '0;
    end else begin
      beats = in_end ? held_inc : LEN_W'(1);
    end

    job.rep        = hit;
    job.count      = beats;
    job.total      = total_after;
    job.stream_end = in_end;
    for (int i = 0; i < LIST_MAX; i++) begin
      job.bytes[i] = (LEN_W'(i) < held_count) ? window[i % PATTERN_MAX] : in_byte;
    end
    job_valid = accept && (beats != '0);
  end

  // next window and control state
  always_comb begin
    held_count_next    = held_count;
    line_matched_next  = line_matched;
    match_counter_next = total_after;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      window_next[i] = window[i];
      if (store && LEN_W'(i) == held_count) begin
        window_next[i] = in_byte;
      end
      if (miss) begin
        if (LEN_W'(i + 1) < held_count) begin
          window_next[i] = window[(i + 1) % PATTERN_MAX];
        end else if (LEN_W'(i + 1) == held_count) begin
          window_next[i] = in_byte;
        end
      end
    end

    if (flush) begin
      held_count_next = '0;
      if (is_nl) begin
        line_matched_next = 1'b0;
      end
    end else if (store) begin
      held_count_next = held_inc;
    end else if (hit) begin
      held_count_next   = '0;
      line_matched_next = 1'b1;
    end

    if (in_end) begin
      held_count_next    = '0;
      line_matched_next  = 1'b0;
      match_counter_next = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count    <= '0;
      line_matched  <= 1'b0;
      match_counter <= '0;
    end else if (accept) begin
      held_count    <= held_count_next;
      line_matched  <= line_matched_next;
      match_counter <= match_counter_next;
    end
  end

  // window bytes, only read below the held count
  always_ff @(posedge clk) begin
    if (accept) begin
      window <= window_next;
    end
  end

  // the window never fills: the held count stays below the window size
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held_count < LEN_W'(PATTERN_MAX))
    else $error("held count reached the window size");

  // a job is only offered while the queue has room
  a_job_room: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> job_ready && job.count != '0)
    else $error("job offered without room or with no beats");

endmodule

`default_nettype wire

### rtl/tfr_queue.sv
// ----------------------------------------------------------------------------
// tfr_queue - two-entry job queue
// Registered fifo between the input side and the output side so that each
// can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module tfr_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire tfr_pkg::job_t  push_data,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output tfr_pkg::job_t       pop_data
);
  import tfr_pkg::*;

  job_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = entry[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // pointers stay one apart exactly when one entry is held
  a_ptr_fill: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr != rd_ptr) == (fill == 2'd1))
    else $error("queue pointers disagree with fill level");

endmodule

`default_nettype wire

### rtl/tfr_back.sv
// ----------------------------------------------------------------------------
// tfr_back - output side of the text find and replace stream
// Walks each queued job one beat per cycle into a registered master stream, unless it stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tfr_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire tfr_pkg::cfg_t  cfg,
  input  wire logic           job_valid,
  output logic                job_ready,
  input  wire tfr_pkg::job_t  job,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output logic [39:0]         m_tdata,
  output logic [1:0]          m_tuser,
  output logic                m_tlast
);
  import tfr_pkg::*;

  logic [POS_W-1:0] pos;
  logic             load;
  logic             beat_last;
  byte_t            beat_byte;

  assign load      = job_valid && (!m_tvalid || m_tready);
  assign beat_last = (LEN_W'(pos) == job.count - LEN_W'(1));
  assign job_ready = load && beat_last;
  assign beat_byte = job.rep ? cfg.replace[pos] : job.bytes[pos];

  // beat position inside the current job
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (load) begin
      pos <= beat_last ? '0 : pos + POS_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {32'(job.total), beat_byte};
      m_tuser <= {job.stream_end && beat_last, job.rep};
      m_tlast <= beat_last;
    end
  end

  // stream end is only flagged on the last beat of a job
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast)
    else $error("stream done shown on a beat that is not last");

endmodule

`default_nettype wire

### rtl/text_find_replace_stream.sv
// ----------------------------------------------------------------------------
// text_find_replace_stream - streaming case-insensitive find and replace
// Configuration registers, input side, job queue and output side.
// ----------------------------------------------------------------------------
// Text enters one byte per beat on the slave stream (tlast marks the final
// byte of the text) and leaves on the master stream. A byte that passes
// through is accepted every cycle while the job queue has room; the input
// side decides at once what the byte causes and queues at most one job, and
// the output side plays each job out at one beat per cycle unless the master
// stream stalls, and the two-entry job queue lets the input keep going. A
// byte that only extends a partial match queues no job and gives no beat.
// The first beat of a byte passes the job queue entry and then the output
// register before it appears on the master stream. Replacement or flush
// bursts of up to 16 beats stall the input once the queue is full.
// Configuration writes are taken every cycle and must only happen while the
// block is idle. Length values of 17 to 31 are clamped to 16 when written.
// ----------------------------------------------------------------------------
`default_nettype none

module text_find_replace_stream (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  // text in
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // text_byte
  input  wire logic        s_tlast,   // stream_end
  // text out
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // out_byte [7:0], match_total [39:8]
  output logic [1:0]       m_tuser,   // from_replacement [0], stream_done [1]
  output logic             m_tlast    // last_of_run
);
  import tfr_pkg::*;

  logic [63:0]      pat_lo;
  logic [63:0]      pat_hi;
  logic [LEN_W-1:0] pat_len;
  logic [63:0]      rep_lo;
  logic [63:0]      rep_hi;
  logic [LEN_W-1:0] rep_len;
  logic             first_only;
  cfg_t             cfg;

  logic             fq_valid;
  logic             fq_ready;
  job_t             fq_job;
  logic             qb_valid;
  logic             qb_ready;
  job_t             qb_job;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pat_lo     <= '0;
      pat_hi     <= '0;
      pat_len    <= '0;
      rep_lo     <= '0;
      rep_hi     <= '0;
      rep_len    <= '0;
      first_only <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PAT_LO:  pat_lo <= cfg_data;
        CFG_PAT_HI:  pat_hi <= cfg_data;
        CFG_PAT_LEN: pat_len <= (cfg_data[4:0] > 5'(PATTERN_MAX)) ?
                                LEN_W'(PATTERN_MAX) : LEN_W'(cfg_data[4:0]);
        CFG_REP_LO:  rep_lo <= cfg_data;
        CFG_REP_HI:  rep_hi <= cfg_data;
        CFG_REP_LEN: rep_len <= (cfg_data[4:0] > 5'(REPLACE_MAX)) ?
                                LEN_W'(REPLACE_MAX) : LEN_W'(cfg_data[4:0]);
        CFG_FIRST:   first_only <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // live configuration record
  always_comb begin
    cfg.pattern        = {pat_hi, pat_lo};
    cfg.pattern_len    = pat_len;
    cfg.replace        = {rep_hi, rep_lo};
    cfg.replace_len    = rep_len;
    cfg.first_per_line = first_only;
  end

  tfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .in_end    (s_tlast),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_job)
  );

  tfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_job)
  );

  tfr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job       (qb_job),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench of the text find and replace stream
// Feeds text bytes through the slave stream under a series of pattern and
// replacement setups, predicts every rewritten beat in a behavioural model
// of the window matcher and compares each master beat against it in order.
// Both stream sides idle in random bursts; one phase holds the output off
// for a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tfr_pkg::*;

  localparam int LIMIT       = 400000;  // cycles before the run is abandoned
  localparam int SETTLE      = 8;       // cycles for beats still in the pipeline
  localparam int LONG_HOLD   = 300;     // long output hold-off
  localparam int MAX_REPORTS = 30;

  // how a random phase picks its lengths
  localparam int SIZE_RANDOM = 0;
  localparam int SIZE_FULL   = 1;
  localparam int SIZE_OVER   = 2;

  localparam logic [2:0] CFG_UNUSED = 3'd7;

  // one beat of rewritten text
  typedef struct packed {
    byte_t       out_byte;
    logic        from_rep;
    logic [31:0] total;
    logic        last;
    logic        done;
  } text_beat_t;

  typedef struct packed {
    byte_t data;
    logic  last;
  } text_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data  = '0;

  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;
  logic        s_tlast  = 1'b0;

  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;    // out_byte [7:0], match_total [39:8]
  logic [1:0]  m_tuser;    // from_replacement [0], stream_done [1]
  logic        m_tlast;    // last_of_run

  text_find_replace_stream u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // matcher model: setup, window state and the beats still owed
  // ---------------------------------------------------------------------------
  logic [63:0] pat_lo = '0, pat_hi = '0, rep_lo = '0, rep_hi = '0;
  logic [4:0]  pat_len = '0, rep_len = '0;
  logic        first_only = 1'b1;

  byte_t       held [PATTERN_MAX];
  int          held_n = 0;
  logic        line_hit = 1'b0;
  logic [31:0] hit_total = '0;

  text_beat_t  burst [$];
  text_beat_t  owed_beats [$];

  // statistics for the summary
  int errors = 0, bytes_in = 0, beats_out = 0, rep_beats = 0;
  int streams_done = 0, matches_seen = 0, cycles = 0;

  function automatic byte_t to_lower(input byte_t c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic void queue_beat(input byte_t b, input logic from_rep);
    text_beat_t t;
    t = '0;
    t.out_byte = b;
    t.from_rep = from_rep;
    burst.insert(burst.size(), t);
  endfunction

  function automatic void flush_held();
    for (int i = 0; i < held_n; i++) queue_beat(held[i], 1'b0);
    held_n = 0;
  endfunction

  // work out the beats that one accepted text byte causes
  function automatic void rewrite_byte(input byte_t b, input logic stream_end);
    int plen, rlen;
    logic active, hit;
    logic [127:0] pat, rep;
    pat  = {pat_hi, pat_lo};
    rep  = {rep_hi, rep_lo};
    plen = (pat_len > PATTERN_MAX) ? PATTERN_MAX : pat_len;
    rlen = (rep_len > REPLACE_MAX) ? REPLACE_MAX : rep_len;
    burst.delete();
    active = plen > 0 && !(first_only && line_hit) && held_n + 1 <= plen;
    if (b == NEWLINE || !active) begin
      flush_held();
      queue_beat(b, 1'b0);
      if (b == NEWLINE) line_hit = 1'b0;
    end else if (held_n + 1 < plen) begin
      held[held_n] = b;
      held_n++;
    end else begin
      hit = to_lower(b) == to_lower(pat[8*(plen-1) +: 8]);
      for (int i = 0; i < held_n; i++) begin
        if (to_lower(held[i]) != to_lower(pat[8*i +: 8])) hit = 1'b0;
      end
      if (hit) begin
        for (int i = 0; i < rlen; i++) queue_beat(rep[8*i +: 8], 1'b1);
        held_n   = 0;
        line_hit = 1'b1;
        matches_seen++;
        if (hit_total != '1) hit_total++;
      end else if (held_n == 0) begin
        queue_beat(b, 1'b0);
      end else begin
        // oldest byte leaves, the window slides by one
        queue_beat(held[0], 1'b0);
        for (int i = 1; i < held_n; i++) held[i-1] = held[i];
        held[held_n-1] = b;
      end
    end
    if (stream_end) begin
      flush_held();
      line_hit = 1'b0;
    end
    foreach (burst[k]) begin
      burst[k].total = hit_total;
      burst[k].last  = (k == burst.size() - 1);
      burst[k].done  = (k == burst.size() - 1) && stream_end;
      owed_beats.insert(owed_beats.size(), burst[k]);
    end
    if (stream_end) hit_total = '0;
  endfunction

  // ---------------------------------------------------------------------------
  // text driver: pops pending bytes, idles in random bursts
  // ---------------------------------------------------------------------------
  text_item_t send_text [$];
  logic       text_taken = 1'b0;
  int         send_gap = 0;
  logic       calm = 1'b0;

  always @(negedge clk) begin
    text_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || text_taken) begin
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (send_text.size() > 0) begin
        it = send_text.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= it.data;
        s_tlast  <= it.last;
        if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 9);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output receiver: random stall bursts and the requested long hold-off
  // ---------------------------------------------------------------------------
  int hold_requests = 0, hold_served = 0, hold_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_served + 1;
      hold_left   = LONG_HOLD;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      hold_left = $urandom_range(0, 8);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on every accepted byte, check every accepted beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    text_beat_t got, want;
    text_taken <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      rewrite_byte(s_tdata, s_tlast);
      bytes_in++;
    end
    if (!rst && m_tvalid && m_tready) begin
      got.out_byte = m_tdata[7:0];
      got.total    = m_tdata[39:8];
      got.from_rep = m_tuser[0];
      got.done     = m_tuser[1];
      got.last     = m_tlast;
      beats_out++;
      if (got.from_rep) rep_beats++;
      if (got.done) streams_done++;
      if (owed_beats.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected beat, expected none, ", $time,
                   "got byte %02h rep %0b total %0d last %0b done %0b",
                   got.out_byte, got.from_rep, got.total, got.last, got.done);
      end else begin
        want = owed_beats.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: beat mismatch, ", $time,
                     "expected byte %02h rep %0b total %0d last %0b done %0b, ",
                     want.out_byte, want.from_rep, want.total, want.last, want.done,
                     "got byte %02h rep %0b total %0d last %0b done %0b",
                     got.out_byte, got.from_rep, got.total, got.last, got.done);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("%0t: run limit reached with %0d beats outstanding", $time, owed_beats.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  byte_t gen_pat [PATTERN_MAX];
  int    gen_len = 0;

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (cfg_idx_t'(idx))
      CFG_PAT_LO:  pat_lo     = value;
      CFG_PAT_HI:  pat_hi     = value;
      CFG_PAT_LEN: pat_len    = value[4:0];
      CFG_REP_LO:  rep_lo     = value;
      CFG_REP_HI:  rep_hi     = value;
      CFG_REP_LEN: rep_len    = value[4:0];
      CFG_FIRST:   first_only = value[0];
      default: ;
    endcase
  endtask

  // full setup, lengths sometimes with junk in the unused upper bits
  task automatic load_setup(input logic [127:0] pat, input int plen,
                            input logic [127:0] rep, input int rlen, input logic first);
    logic [63:0] junk;
    junk = ($urandom_range(0, 1) == 0) ? '0 : {$urandom, $urandom};
    write_reg(CFG_PAT_LO, pat[63:0]);
    write_reg(CFG_PAT_HI, pat[127:64]);
    write_reg(CFG_PAT_LEN, {junk[63:5], 5'(plen)});
    write_reg(CFG_REP_LO, rep[63:0]);
    write_reg(CFG_REP_HI, rep[127:64]);
    write_reg(CFG_REP_LEN, {junk[63:5], 5'(rlen)});
    write_reg(CFG_FIRST, {junk[63:1], first});
    if ($urandom_range(0, 1) == 0) write_reg(CFG_UNUSED, {$urandom, $urandom});
    @(negedge clk);
    cfg_valid <= 1'b0;
    for (int i = 0; i < PATTERN_MAX; i++) gen_pat[i] = pat[8*i +: 8];
    gen_len = (plen > PATTERN_MAX) ? PATTERN_MAX : plen;
  endtask

  // wait until every owed beat is out, then let the pipeline settle
  task automatic wait_drained();
    do @(posedge clk);
    while (send_text.size() != 0 || s_tvalid || owed_beats.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic void add_text(input byte_t b, input logic last);
    text_item_t it;
    it.data = b;
    it.last = last;
    send_text.insert(send_text.size(), it);
  endfunction

  function automatic void add_string(input string s, input logic end_at_last);
    for (int i = 0; i < s.len(); i++) add_text(s[i], end_at_last && i == s.len() - 1);
  endfunction

  function automatic logic [127:0] pack_text(input string s);
    logic [127:0] w;
    w = '0;
    for (int i = 0; i < s.len() && i < 16; i++) w[8*i +: 8] = s[i];
    return w;
  endfunction

  function automatic byte_t flip_case(input byte_t c);
    if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) && $urandom_range(0, 1) == 1)
      return c ^ 8'h20;
    return c;
  endfunction

  // one phase of random setup and mostly well-formed text around the pattern
  task automatic random_phase(input int items, input int size_pick, input logic long_hold);
    logic [127:0] pat, rep;
    int plen, rlen, kind, n, r, part;
    pat  = '0;
    rep  = {$urandom, $urandom, $urandom, $urandom};
    kind = $urandom_range(0, 3);
    for (int i = 0; i < 16; i++) begin
      case (kind)
        0:       pat[8*i +: 8] = 8'($urandom_range(0, 255));
        1:       pat[8*i +: 8] = flip_case(8'($urandom_range("a", "z")));
        2:       pat[8*i +: 8] = flip_case(8'($urandom_range("a", "b")));
        default: pat[8*i +: 8] = flip_case(8'($urandom_range("a", "c")));
      endcase
    end
    case (size_pick)
      SIZE_FULL: begin
        plen = PATTERN_MAX;
        rlen = REPLACE_MAX;
      end
      SIZE_OVER: begin
        plen = $urandom_range(17, 31);
        rlen = $urandom_range(17, 31);
      end
      default: begin
        r = $urandom_range(0, 9);
        plen = (r == 0) ? 0 : (r == 1) ? 16 : (r == 2) ? $urandom_range(17, 31)
                                                    : $urandom_range(1, 6);
        r = $urandom_range(0, 9);
        rlen = (r == 0) ? 0 : (r == 1) ? 16 : (r == 2) ? $urandom_range(17, 31)
                                                    : $urandom_range(1, 5);
      end
    endcase
    load_setup(pat, plen, rep, rlen, 1'($urandom_range(0, 1)));
    n = 0;
    while (n < items) begin
      r = $urandom_range(0, 99);
      if (r < 35 && gen_len > 0) begin
        // whole pattern in random letter case
        for (int i = 0; i < gen_len; i++) add_text(flip_case(gen_pat[i]), 1'b0);
        n += gen_len;
      end else if (r < 50 && gen_len > 1) begin
        // broken pattern: a prefix, then anything
        part = $urandom_range(1, gen_len - 1);
        for (int i = 0; i < part; i++) add_text(flip_case(gen_pat[i]), 1'b0);
        add_text(8'($urandom_range(0, 255)), 1'b0);
        n += part + 1;
      end else if (r < 58) begin
        add_text(NEWLINE, 1'b0);
        n++;
      end else if (r < 62) begin
        add_text(flip_case(gen_pat[$urandom_range(0, 15)]), 1'b1);
        n++;
      end else if (r < 80) begin
        add_text(flip_case(gen_pat[$urandom_range(0, 15)]), 1'b0);
        n++;
      end else begin
        add_text(8'($urandom_range(0, 255)), 1'b0);
        n++;
      end
    end
    if (long_hold) hold_requests++;
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset setup: matching off, bytes pass straight through
    add_text(8'h00, 1'b0);
    add_text(8'hFF, 1'b0);
    add_text(NEWLINE, 1'b0);
    add_text("A", 1'b1);
    wait_drained();

    // three-byte pattern, every match: hit, slide, newline flush, end flush,
    // and a phase ending with bytes still held
    load_setup(pack_text("aBc"), 3, pack_text("XY"), 2, 1'b0);
    add_string("AbCabd\nab", 1'b1);
    add_string("xaBCab", 1'b0);
    wait_drained();

    // one-byte pattern deleted, first only: shorter pattern flushes the
    // held bytes, repeat on a line passes, final byte deleted with no beats
    load_setup(pack_text("Z"), 1, '0, 0, 1'b1);
    add_string("zzz\n", 1'b0);
    add_text("Z", 1'b1);
    wait_drained();

    // random phases, the last one with no idling on either side
    random_phase(62, SIZE_FULL, 1'b0);
    random_phase(62, SIZE_OVER, 1'b0);
    random_phase(62, SIZE_RANDOM, 1'b1);
    for (int p = 0; p < 4; p++) random_phase(62, SIZE_RANDOM, 1'b0);
    calm = 1'b1;
    random_phase(62, SIZE_RANDOM, 1'b0);

    $display("tb_top: %0d text bytes in, %0d beats out (%0d from replacements)",
             bytes_in, beats_out, rep_beats);
    $display("tb_top: %0d matches predicted, %0d streams closed, %0d mismatches",
             matches_seen, streams_done, errors);
    if (errors == 0 && owed_beats.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
